>>> sv/dof_pkg.sv
// ----------------------------------------------------------------------------
// Drop-oldest event FIFO package
// Shared command, result and storage entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package dof_pkg;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_STATUS = 2'd3
  } dof_kind_e;

  localparam int unsigned FillW = 5;
  localparam int unsigned CountW = 32;

  typedef struct packed {
    dof_kind_e   kind;
    logic [7:0]  event_type;
    logic [63:0] event_payload;
    logic [63:0] event_time;
  } dof_cmd_t;

  typedef struct packed {
    logic              status;
    logic [7:0]        out_type;
    logic [63:0]       out_payload;
    logic [63:0]       out_time;
    logic [FillW-1:0]  fill_count;
    logic              is_empty;
    logic [CountW-1:0] overflow_count;
  } dof_res_t;

  typedef struct packed {
    logic [7:0]  event_type;
    logic [63:0] event_payload;
    logic [63:0] event_time;
  } dof_entry_t;

endpackage

`default_nettype wire

>>> sv/drop_oldest_event_fifo.sv
// ----------------------------------------------------------------------------
// Drop-oldest event FIFO
// Ring queue of timestamped events; a put into a full queue drops the oldest.
//
// Channel   Signals                 Direction  Transfer
// command   start, busy, cmd_i      in         start high and busy low
// result    res_valid_o, res_o      out        res_valid_o high, one cycle
//
// Every command yields one result in the cycle after it is taken.
// A command is taken in every cycle; busy stays low.
// The read port of the event memory is registered. Reset clears both
// pointers and the overflow count; the memory contents are not cleared.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module drop_oldest_event_fifo
  import dof_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output      logic     busy,
  input  wire dof_cmd_t cmd_i,
  output      logic     res_valid_o,
  output      dof_res_t res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] DepthP = PW'(DEPTH);
  localparam logic [PW-1:0] OneP = PW'(1);

  logic [PW-1:0]     rd_q, rd_d;
  logic [PW-1:0]     wr_q, wr_d;
  logic [CountW-1:0] dropped_q, dropped_d;
  logic              res_valid_q;
  logic              status_q, status_d;
  logic              get_ok_q, get_ok_d;

  logic              accept;
  logic [PW-1:0]     fill_now;
  logic [PW-1:0]     fill_out;
  logic [PW+4:0]     fill_ext;
  logic              mem_we;
  logic              mem_re;
  dof_entry_t        wdata;
  dof_entry_t        rdata;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign fill_now = wr_q - rd_q;

  always_comb begin
    rd_d      = rd_q;
    wr_d      = wr_q;
    dropped_d = dropped_q;
    status_d  = 1'b0;
    get_ok_d  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    if (accept) begin
      unique case (cmd_i.kind)
        KIND_PUT: begin
          if (fill_now == DepthP) begin
            rd_d = rd_q + OneP;
            if (dropped_q != '1) begin
              dropped_d = dropped_q + CountW'(1);
            end
          end
          wr_d   = wr_q + OneP;
          mem_we = 1'b1;
        end
        KIND_GET: begin
          if (fill_now == '0) begin
            status_d = 1'b1;
          end else begin
            rd_d     = rd_q + OneP;
            get_ok_d = 1'b1;
            mem_re   = 1'b1;
          end
        end
        KIND_CLEAR: begin
          rd_d = '0;
          wr_d = '0;
        end
        KIND_STATUS: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= '0;
      wr_q        <= '0;
      dropped_q   <= '0;
      res_valid_q <= 1'b0;
      status_q    <= 1'b0;
      get_ok_q    <= 1'b0;
    end else begin
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      dropped_q   <= dropped_d;
      res_valid_q <= accept;
      status_q    <= status_d;
      get_ok_q    <= get_ok_d;
    end
  end

  assign wdata.event_type    = cmd_i.event_type;
  assign wdata.event_payload = cmd_i.event_payload;
  assign wdata.event_time    = cmd_i.event_time;

  dof_event_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wr_q[AW-1:0]),
    .wdata_i(wdata),
    .re_i   (mem_re),
    .raddr_i(rd_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // The pointers already hold the state after the step during the result cycle.
  assign fill_out = wr_q - rd_q;
  assign fill_ext = {5'b0, fill_out};

  assign res_valid_o          = res_valid_q;
  assign res_o.status         = status_q;
  assign res_o.out_type       = get_ok_q ? rdata.event_type : '0;
  assign res_o.out_payload    = get_ok_q ? rdata.event_payload : '0;
  assign res_o.out_time       = get_ok_q ? rdata.event_time : '0;
  assign res_o.fill_count     = fill_ext[FillW-1:0];
  assign res_o.is_empty       = (fill_out == '0);
  assign res_o.overflow_count = dropped_q;

endmodule

`default_nettype wire

>>> sv/dof_event_mem.sv
// ----------------------------------------------------------------------------
// Event storage memory
// One write port and one registered read port over DEPTH event entries.
// ----------------------------------------------------------------------------
`default_nettype none

module dof_event_mem
  import dof_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire dof_entry_t               wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      dof_entry_t               rdata_o
);

  dof_entry_t mem [DEPTH];
  dof_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/dof_checker.sv
// ----------------------------------------------------------------------------
// Drop-oldest event FIFO checker
// Port-level properties of the FIFO, bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dof_checker
  import dof_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire dof_cmd_t cmd_i,
  input wire logic     res_valid_o,
  input wire dof_res_t res_o
);

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> res_valid_o)
    else $error("A command transfer did not produce a result.");

  a_empty_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status |-> res_o.is_empty && res_o.out_type == '0
      && res_o.out_payload == '0 && res_o.out_time == '0)
    else $error("An empty get reported data or a nonempty queue.");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.is_empty |-> res_o.fill_count == '0)
    else $error("An empty queue reported a nonzero fill count.");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.kind == KIND_CLEAR |=> res_o.is_empty)
    else $error("A clear left entries in the queue.");

  a_ovf_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(res_valid_o) |->
      res_o.overflow_count >= $past(res_o.overflow_count))
    else $error("The overflow count decreased.");

endmodule

bind drop_oldest_event_fifo dof_checker u_dof_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .cmd_i      (cmd_i),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

`default_nettype wire
